// ----- design/flash_save_memory_emulator_macros.svh -----
// Assertion shorthands for the flash save memory emulator checkers.
`ifndef FLASH_SAVE_MEMORY_EMULATOR_MACROS_SVH
`define FLASH_SAVE_MEMORY_EMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fsme_pkg.sv -----
package fsme_pkg;

    // geometry, all powers of two
    localparam int PAGE_BYTES   = 128;
    localparam int SECTOR_BYTES = 16384;
    localparam int FLASH_BYTES  = 131072;

    localparam int NUM_PAGES    = FLASH_BYTES / PAGE_BYTES;
    localparam int SECTOR_PAGES = SECTOR_BYTES / PAGE_BYTES;

    localparam int ADDR_W = $clog2(FLASH_BYTES);
    localparam int IDX_W  = $clog2(PAGE_BYTES);
    localparam int PG_W   = $clog2(NUM_PAGES);
    localparam int SEC_W  = $clog2(SECTOR_PAGES);

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_FULL_EMU    = 2'd0;
    localparam logic [1:0] CFG_WRITE_DELAY = 2'd1;
    localparam logic [1:0] CFG_ERASE_DELAY = 2'd2;

    localparam logic       RST_FULL_EMU    = 1'b1;
    localparam logic [7:0] RST_WRITE_DELAY = 8'd3;
    localparam logic [7:0] RST_ERASE_DELAY = 8'd200;

    typedef enum logic [2:0] {
        ACT_LOAD      = 3'd0,
        ACT_READ      = 3'd1,
        ACT_PROGRAM   = 3'd2,
        ACT_ERASE_SEC = 3'd3,
        ACT_ERASE_ALL = 3'd4,
        ACT_TICK      = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROG,
        ST_PROG_END,
        ST_ERASE
    } t_state;

    typedef struct packed {
        logic       full_emu;
        logic [7:0] write_delay_ticks;
        logic [7:0] erase_delay_ticks;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_store_req;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_buf_req;

endpackage

// ----- design/fsme_chan_if.sv -----
// command word channel
interface fsme_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [9:0] page;
    logic [6:0] byte_index;
    logic [7:0] data;

    modport source (output valid, action, page, byte_index, data, input ready);
    modport sink   (input valid, action, page, byte_index, data, output ready);
endinterface

// result word channel
interface fsme_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, read_data, done_res, busy_res, rejected, input ready);
    modport sink   (input valid, read_data, done_res, busy_res, rejected, output ready);
endinterface

// ----- design/fsme_ram.sv -----
// simple dual-port RAM, registered read
module fsme_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/fsme_ctrl.sv -----
// command decode, busy timer, program/erase sequencer, result stages
module fsme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsme_pkg::t_cfg      i_cfg,
    fsme_in_if.sink             i_in_chan,
    fsme_out_if.source          o_out_chan,
    output fsme_pkg::t_store_req o_store_req,
    input  logic [7:0]          i_store_q,
    output fsme_pkg::t_buf_req  o_buf_req,
    input  logic [7:0]          i_buf_q
);

    fsme_pkg::t_state r_state, n_state;

    logic [fsme_pkg::ADDR_W-1:0] r_base, n_base;
    logic [fsme_pkg::ADDR_W-1:0] r_last, n_last;
    logic [fsme_pkg::ADDR_W-1:0] r_cnt;
    logic [fsme_pkg::ADDR_W-1:0] walk_addr;
    logic                        r_and_mode;
    logic                        r_wr_vld;
    logic [fsme_pkg::ADDR_W-1:0] r_wr_addr;

    logic       r_busy, n_busy;
    logic [7:0] r_ticks, n_ticks;

    // stage 1: result known at accept, read byte still in RAM
    logic r_s1_vld, r_s1_is_rd, r_s1_done, r_s1_busy, r_s1_rej;
    // stage 2: output register
    logic       r_o_vld, r_o_done, r_o_busy, r_o_rej;
    logic [7:0] r_o_rd;

    fsme_pkg::t_action           act;
    logic [fsme_pkg::PG_W-1:0]   pg;
    logic [fsme_pkg::IDX_W-1:0]  idx;
    logic                        c_is_rd, c_done, c_rej;
    logic                        start_prog, start_erase;

    logic o_free, s1_move, in_ready, in_acc;

    assign o_free   = !r_o_vld || o_out_chan.ready;
    assign s1_move  = r_s1_vld && o_free;
    assign in_ready = (r_state == fsme_pkg::ST_IDLE) && (!r_s1_vld || o_free);
    assign in_acc   = i_in_chan.valid && in_ready;

    assign act = fsme_pkg::t_action'(i_in_chan.action);
    assign pg  = fsme_pkg::PG_W'(i_in_chan.page);
    assign idx = fsme_pkg::IDX_W'(i_in_chan.byte_index);

    assign walk_addr = r_base + r_cnt;

    // command decode and busy timer
    always_comb begin
        logic [7:0]                delay;
        logic [7:0]                t_left;
        logic [fsme_pkg::PG_W-1:0] pg_al;
        n_busy      = r_busy;
        n_ticks     = r_ticks;
        n_base      = r_base;
        n_last      = r_last;
        c_is_rd     = 1'b0;
        c_done      = 1'b0;
        c_rej       = 1'b0;
        start_prog  = 1'b0;
        start_erase = 1'b0;
        delay       = i_cfg.erase_delay_ticks;
        t_left      = r_ticks;
        pg_al       = (pg >> fsme_pkg::SEC_W) << fsme_pkg::SEC_W;
        case (act)
            fsme_pkg::ACT_LOAD: begin
            end
            fsme_pkg::ACT_READ: begin
                c_is_rd = 1'b1;
            end
            fsme_pkg::ACT_PROGRAM: begin
                if (r_busy) begin
                    c_rej = 1'b1;
                end else begin
                    start_prog = 1'b1;
                    delay      = i_cfg.write_delay_ticks;
                    n_base     = {pg, {fsme_pkg::IDX_W{1'b0}}};
                end
            end
            fsme_pkg::ACT_ERASE_SEC: begin
                if (r_busy) begin
                    c_rej = 1'b1;
                end else begin
                    start_erase = 1'b1;
                    n_base      = {pg_al, {fsme_pkg::IDX_W{1'b0}}};
                    n_last      = fsme_pkg::ADDR_W'(fsme_pkg::SECTOR_BYTES - 1);
                end
            end
            fsme_pkg::ACT_ERASE_ALL: begin
                if (r_busy) begin
                    c_rej = 1'b1;
                end else begin
                    start_erase = 1'b1;
                    n_base      = '0;
                    n_last      = fsme_pkg::ADDR_W'(fsme_pkg::FLASH_BYTES - 1);
                end
            end
            fsme_pkg::ACT_TICK: begin
                if (r_busy) begin
                    if (r_ticks != 8'd0) begin
                        t_left = r_ticks - 8'd1;
                    end
                    n_ticks = t_left;
                    if (t_left == 8'd0) begin
                        n_busy = 1'b0;
                        c_done = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        // busy period starts with the command, memory walk runs alongside
        if (start_prog || start_erase) begin
            if (i_cfg.full_emu && delay != 8'd0) begin
                n_busy  = 1'b1;
                n_ticks = delay;
            end else begin
                c_done = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fsme_pkg::ST_IDLE: begin
                if (in_acc && start_prog) begin
                    n_state = fsme_pkg::ST_PROG;
                end else if (in_acc && start_erase) begin
                    n_state = fsme_pkg::ST_ERASE;
                end
            end
            fsme_pkg::ST_PROG: begin
                if (r_cnt == fsme_pkg::ADDR_W'(fsme_pkg::PAGE_BYTES - 1)) begin
                    n_state = fsme_pkg::ST_PROG_END;
                end
            end
            fsme_pkg::ST_PROG_END: begin
                n_state = fsme_pkg::ST_IDLE;
            end
            fsme_pkg::ST_ERASE: begin
                if (r_cnt == r_last) begin
                    n_state = fsme_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsme_pkg::ST_IDLE;
            end
        endcase
    end

    // memory requests
    always_comb begin
        o_store_req = '0;
        o_buf_req   = '0;
        case (r_state)
            fsme_pkg::ST_IDLE: begin
                o_store_req.re    = in_acc && (act == fsme_pkg::ACT_READ);
                o_store_req.raddr = {pg, idx};
                o_buf_req.we      = in_acc && (act == fsme_pkg::ACT_LOAD);
                o_buf_req.waddr   = idx;
                o_buf_req.wdata   = i_in_chan.data;
            end
            fsme_pkg::ST_PROG: begin
                o_store_req.re    = 1'b1;
                o_store_req.raddr = walk_addr;
                o_buf_req.re      = 1'b1;
                o_buf_req.raddr   = r_cnt[fsme_pkg::IDX_W-1:0];
            end
            fsme_pkg::ST_PROG_END: begin
            end
            fsme_pkg::ST_ERASE: begin
                o_store_req.we    = 1'b1;
                o_store_req.waddr = walk_addr;
                o_store_req.wdata = fsme_pkg::ERASED_BYTE;
            end
            default: begin
            end
        endcase
        // write-back of the byte read in the previous cycle
        if (r_wr_vld) begin
            o_store_req.we    = 1'b1;
            o_store_req.waddr = r_wr_addr;
            o_store_req.wdata = r_and_mode ? (i_store_q & i_buf_q) : i_buf_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fsme_pkg::ST_IDLE;
            r_busy   <= 1'b0;
            r_ticks  <= 8'd0;
            r_wr_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr_vld <= (r_state == fsme_pkg::ST_PROG);
            if (in_acc) begin
                r_busy  <= n_busy;
                r_ticks <= n_ticks;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_o_vld <= 1'b1;
            end else if (o_out_chan.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr <= walk_addr;
        if (r_state == fsme_pkg::ST_IDLE) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + fsme_pkg::ADDR_W'(1);
        end
        if (in_acc) begin
            r_base     <= n_base;
            r_last     <= n_last;
            r_and_mode <= i_cfg.full_emu;
            r_s1_is_rd <= c_is_rd;
            r_s1_done  <= c_done;
            r_s1_busy  <= n_busy;
            r_s1_rej   <= c_rej;
        end
        if (s1_move) begin
            r_o_rd   <= r_s1_is_rd ? i_store_q : 8'd0;
            r_o_done <= r_s1_done;
            r_o_busy <= r_s1_busy;
            r_o_rej  <= r_s1_rej;
        end
    end

    assign i_in_chan.ready      = in_ready;
    assign o_out_chan.valid     = r_o_vld;
    assign o_out_chan.read_data = r_o_rd;
    assign o_out_chan.done_res  = r_o_done;
    assign o_out_chan.busy_res  = r_o_busy;
    assign o_out_chan.rejected  = r_o_rej;

endmodule

// ----- design/flash_save_memory_emulator.sv -----
// Channel     | Dir | Word
// ------------+-----+----------------------------------------------------
// i_in_chan   | in  | action, page, byte_index, data (valid/ready)
// o_out_chan  | out | read_data, done_res, busy_res, rejected (valid/ready)
// i_cfg_*     | in  | write enable, register index, 8-bit data; no read-back
//
// Buffer loads, reads, ticks and idle codes start no store walk; a result word
// passes the stage-1 register, which waits on the store read, then the output stage.
// Page program, sector erase and chip erase hold ready low while the sequencer
// walks the page, sector or whole store: the store has one write port and
// the sequencer moves one byte per cycle through it.
// Reset (i_rst_n low, synchronous) clears busy, tick count, sequencer and
// valids and loads the register defaults; store and page buffer keep contents.
// Two result stages let a command be taken while an earlier word is stalled.
module flash_save_memory_emulator (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsme_in_if.sink    i_in_chan,
    fsme_out_if.source o_out_chan,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    fsme_pkg::t_cfg       r_cfg;
    fsme_pkg::t_store_req store_req;
    fsme_pkg::t_buf_req   buf_req;
    logic [7:0]           store_q;
    logic [7:0]           buf_q;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_emu          <= fsme_pkg::RST_FULL_EMU;
            r_cfg.write_delay_ticks <= fsme_pkg::RST_WRITE_DELAY;
            r_cfg.erase_delay_ticks <= fsme_pkg::RST_ERASE_DELAY;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fsme_pkg::CFG_FULL_EMU:    r_cfg.full_emu          <= i_cfg_data[0];
                fsme_pkg::CFG_WRITE_DELAY: r_cfg.write_delay_ticks <= i_cfg_data;
                fsme_pkg::CFG_ERASE_DELAY: r_cfg.erase_delay_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer, timer and result stages
    fsme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_chan   (i_in_chan),
        .o_out_chan  (o_out_chan),
        .o_store_req (store_req),
        .i_store_q   (store_q),
        .o_buf_req   (buf_req),
        .i_buf_q     (buf_q)
    );

    // flash byte store: one write and one read per cycle
    fsme_ram #(
        .DEPTH (fsme_pkg::FLASH_BYTES),
        .WIDTH (8)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_req.we),
        .i_waddr (store_req.waddr),
        .i_wdata (store_req.wdata),
        .i_re    (store_req.re),
        .i_raddr (store_req.raddr),
        .o_rdata (store_q)
    );

    // page buffer: loads write, program walk reads
    fsme_ram #(
        .DEPTH (fsme_pkg::PAGE_BYTES),
        .WIDTH (8)
    ) u_page_buf (
        .i_clk   (i_clk),
        .i_we    (buf_req.we),
        .i_waddr (buf_req.waddr),
        .i_wdata (buf_req.wdata),
        .i_re    (buf_req.re),
        .i_raddr (buf_req.raddr),
        .o_rdata (buf_q)
    );

endmodule

// ----- design/fsme_checker.sv -----
`include "flash_save_memory_emulator_macros.svh"

// port-level checks on the result channel
module fsme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_read_data,
    input logic       i_done_res,
    input logic       i_busy_res,
    input logic       i_rejected
);

    // stalled word holds
    `FSME_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_read_data) && $stable(i_done_res) && $stable(i_busy_res) && $stable(i_rejected), "result word changed while stalled")

    // completion always leaves the device idle
    `FSME_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, i_out_valid && i_done_res, !i_busy_res, "done with busy still set")

    // a rejected command only happens while busy, and busy stays
    `FSME_ASSERT_IMP(a_rej_busy, i_clk, i_rst_n, i_out_valid && i_rejected, i_busy_res && !i_done_res, "reject without busy")

    // read bytes come only from read commands, which never complete or reject
    `FSME_ASSERT_IMP(a_rd_clean, i_clk, i_rst_n, i_out_valid && (i_read_data != 8'd0), !i_done_res && !i_rejected, "read data on a non-read word")

endmodule

bind flash_save_memory_emulator fsme_checker u_fsme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_chan.valid),
    .i_out_ready (o_out_chan.ready),
    .i_read_data (o_out_chan.read_data),
    .i_done_res  (o_out_chan.done_res),
    .i_busy_res  (o_out_chan.busy_res),
    .i_rejected  (o_out_chan.rejected)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    // Actions 6 and 7 are not decoded: they only report the busy state.
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int IDLE_PCT    = 30;         // percent of cycles a side sits out
    localparam int HOLD_CYCLES = 80;         // long result-side stall, fills the block
    localparam int CYCLE_LIMIT = 3_000_000;  // hard stop, several times the slowest run

    typedef struct packed {
        logic [2:0] action;
        logic [9:0] page;
        logic [6:0] byte_index;
        logic [7:0] data;
    } t_flash_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       rejected;
    } t_flash_res;

    // Shadow copy of the save memory: predicts one result word per command word
    // and holds the predictions until the block hands its words back in order.
    class save_mem_scoreboard;
        logic [7:0] shadow_mem  [fsme_pkg::FLASH_BYTES];
        logic [7:0] shadow_page [fsme_pkg::PAGE_BYTES];
        bit         op_busy;
        logic [7:0] ticks_remaining;
        bit         cfg_full;
        logic [7:0] cfg_wr_ticks;
        logic [7:0] cfg_er_ticks;
        t_flash_res pending_results [$];
        int         walk_tail;   // cycles the last command keeps the store port
        int         errors;
        int         words_in;
        int         words_out;
        int         n_done;
        int         n_rejected;

        function new();
            op_busy         = 1'b0;
            ticks_remaining = '0;
            cfg_full        = fsme_pkg::RST_FULL_EMU;
            cfg_wr_ticks    = fsme_pkg::RST_WRITE_DELAY;
            cfg_er_ticks    = fsme_pkg::RST_ERASE_DELAY;
            walk_tail       = 0;
            errors          = 0;
            words_in        = 0;
            words_out       = 0;
            n_done          = 0;
            n_rejected      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] value);
            case (idx)
                fsme_pkg::CFG_FULL_EMU:    cfg_full     = value[0];
                fsme_pkg::CFG_WRITE_DELAY: cfg_wr_ticks = value;
                fsme_pkg::CFG_ERASE_DELAY: cfg_er_ticks = value;
                default: ;
            endcase
        endfunction

        // Returns 1 when the operation finishes right away.
        function bit start_op(logic [7:0] ticks);
            if (cfg_full && ticks != 0) begin
                op_busy         = 1'b1;
                ticks_remaining = ticks;
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void apply_command(t_flash_cmd c);
            t_flash_res r;
            int         base;
            r         = '0;
            walk_tail = 0;
            base      = c.page * fsme_pkg::PAGE_BYTES;
            words_in++;
            case (c.action)
                fsme_pkg::ACT_LOAD: shadow_page[c.byte_index] = c.data;
                fsme_pkg::ACT_READ: r.read_data = shadow_mem[base + c.byte_index];
                fsme_pkg::ACT_PROGRAM: begin
                    if (op_busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        for (int k = 0; k < fsme_pkg::PAGE_BYTES; k++)
                            shadow_mem[base + k] = cfg_full ?
                                (shadow_mem[base + k] & shadow_page[k]) : shadow_page[k];
                        r.done_res = start_op(cfg_wr_ticks);
                        walk_tail  = fsme_pkg::PAGE_BYTES + 1;
                    end
                end
                fsme_pkg::ACT_ERASE_SEC: begin
                    if (op_busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        base = (c.page / fsme_pkg::SECTOR_PAGES) * fsme_pkg::SECTOR_BYTES;
                        for (int k = 0; k < fsme_pkg::SECTOR_BYTES; k++)
                            shadow_mem[base + k] = fsme_pkg::ERASED_BYTE;
                        r.done_res = start_op(cfg_er_ticks);
                        walk_tail  = fsme_pkg::SECTOR_BYTES;
                    end
                end
                fsme_pkg::ACT_ERASE_ALL: begin
                    if (op_busy) begin
                        r.rejected = 1'b1;
                    end else begin
                        for (int k = 0; k < fsme_pkg::FLASH_BYTES; k++)
                            shadow_mem[k] = fsme_pkg::ERASED_BYTE;
                        r.done_res = start_op(cfg_er_ticks);
                        walk_tail  = fsme_pkg::FLASH_BYTES;
                    end
                end
                fsme_pkg::ACT_TICK: begin
                    if (op_busy) begin
                        if (ticks_remaining != 0)
                            ticks_remaining--;
                        if (ticks_remaining == 0) begin
                            op_busy    = 1'b0;
                            r.done_res = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            r.busy_res = op_busy;
            n_done     += r.done_res;
            n_rejected += r.rejected;
            pending_results.push_back(r);
        endfunction

        function void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
            errors++;
            $display("%0t: %s mismatch on result word %0d: expected %h, got %h",
                     $time, field, words_out, want, got);
        endfunction

        function void match_result(t_flash_res got);
            t_flash_res want;
            words_out++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, got %h/%b/%b/%b",
                         $time, got.read_data, got.done_res, got.busy_res, got.rejected);
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                flag_mismatch("read_data", want.read_data, got.read_data);
            if (got.done_res !== want.done_res)
                flag_mismatch("done_res", want.done_res, got.done_res);
            if (got.busy_res !== want.busy_res)
                flag_mismatch("busy_res", want.busy_res, got.busy_res);
            if (got.rejected !== want.rejected)
                flag_mismatch("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [7:0] i_cfg_data;

    fsme_in_if  in_if ();
    fsme_out_if out_if ();

    flash_save_memory_emulator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_if),
        .o_out_chan (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    save_mem_scoreboard sb = new();

    bit calm     = 1'b0;   // both sides run flat out while set
    bit hold_req = 1'b0;   // set by the stimulus, consumed by the result side
    int hold_left = 0;
    int cycle_count;

    // Erases are long store walks; keep their number down so the run stays short.
    int sector_budget = 14;
    int chip_budget   = 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or drops a word.
    initial begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off counted here so
    // the output stages fill up and the block has to drop ready on its input.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Result monitor: every accepted word goes against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready)
            sb.match_result({out_if.read_data, out_if.done_res, out_if.busy_res,
                             out_if.rejected});
    end

    // Offer one command word, idling at random first; the word counts once it
    // is taken at a rising edge. Valid is only ever set once per falling edge.
    task automatic send_word(input t_flash_cmd c);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.action     <= c.action;
        in_if.page       <= c.page;
        in_if.byte_index <= c.byte_index;
        in_if.data       <= c.data;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.apply_command(c);
    endtask

    task automatic issue(input logic [2:0] act, input logic [9:0] pg,
                         input logic [6:0] idx, input logic [7:0] dat);
        send_word({act, pg, idx, dat});
    endtask

    // Wait until every word is back and the last store walk has had time to end.
    task automatic drain(input int extra);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (sb.walk_tail + extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Registers change only with the pipe empty. An operation still timing out
    // keeps counting ticks across the change.
    task automatic configure(input logic full, input logic [7:0] wr_ticks,
                             input logic [7:0] er_ticks, input bit squeeze);
        drain(4);
        hold_req = squeeze;
        write_reg(fsme_pkg::CFG_FULL_EMU, {7'd0, full});
        write_reg(fsme_pkg::CFG_WRITE_DELAY, wr_ticks);
        write_reg(fsme_pkg::CFG_ERASE_DELAY, er_ticks);
    endtask

    // A few hot pages around sector edges so reads hit programmed data.
    function automatic logic [9:0] pick_page();
        case ($urandom_range(0, 9))
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'd895;
            3: return 10'd896;
            4: return 10'd127;
            5: return 10'd128;
            default: return 10'($urandom_range(0, fsme_pkg::NUM_PAGES - 1));
        endcase
    endfunction

    // While busy the stream is mostly ticks so operations finish; the rest
    // are commands that must bounce, plus loads, reads and spare codes.
    function automatic t_flash_cmd pick_cmd(input int tick_pct);
        t_flash_cmd c;
        int         roll;
        c.page       = pick_page();
        c.byte_index = 7'($urandom_range(0, fsme_pkg::PAGE_BYTES - 1));
        c.data       = 8'($urandom_range(0, 255));
        roll         = $urandom_range(0, 999);
        if (sb.op_busy) begin
            if (roll < tick_pct * 10) begin
                c.action = fsme_pkg::ACT_TICK;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    c.action = fsme_pkg::ACT_PROGRAM;
                    2:       c.action = fsme_pkg::ACT_ERASE_SEC;
                    3:       c.action = fsme_pkg::ACT_ERASE_ALL;
                    4, 5, 6: c.action = fsme_pkg::ACT_READ;
                    7, 8:    c.action = fsme_pkg::ACT_LOAD;
                    default: c.action = roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
                endcase
            end
        end else if (roll < 350) begin
            c.action = fsme_pkg::ACT_LOAD;
        end else if (roll < 600) begin
            c.action = fsme_pkg::ACT_READ;
        end else if (roll < 760) begin
            c.action = fsme_pkg::ACT_PROGRAM;
        end else if (roll < 800 && sector_budget > 0) begin
            c.action = fsme_pkg::ACT_ERASE_SEC;
            sector_budget--;
        end else if (roll < 805 && chip_budget > 0) begin
            c.action = fsme_pkg::ACT_ERASE_ALL;
            chip_budget--;
        end else if (roll < 960) begin
            c.action = fsme_pkg::ACT_TICK;
        end else begin
            c.action = roll[0] ? ACT_SPARE_HI : ACT_SPARE_LO;
        end
        return c;
    endfunction

    task automatic run_phase(input logic full, input logic [7:0] wr_ticks,
                             input logic [7:0] er_ticks, input int n_words,
                             input int tick_pct, input bit quiet, input bit squeeze);
        calm = quiet;
        configure(full, wr_ticks, er_ticks, squeeze);
        for (int n = 0; n < n_words; n++)
            send_word(pick_cmd(tick_pct));
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = fsme_pkg::CFG_FULL_EMU;
        i_cfg_data       = '0;
        in_if.valid      = 1'b0;
        in_if.action     = fsme_pkg::ACT_LOAD;
        in_if.page       = '0;
        in_if.byte_index = '0;
        in_if.data       = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: full emulation, 3 write ticks, 200 erase ticks.
        // Chip erase first so no store byte is ever read before it is defined.
        issue(fsme_pkg::ACT_ERASE_ALL, 10'd0, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd1023, 7'd127, 8'd0);
        issue(fsme_pkg::ACT_PROGRAM, 10'd0, 7'd0, 8'd0);        // bounces, still busy
        issue(fsme_pkg::ACT_ERASE_SEC, 10'd0, 7'd0, 8'd0);      // bounces
        issue(fsme_pkg::ACT_ERASE_ALL, 10'd1023, 7'd0, 8'd0);   // bounces
        issue(ACT_SPARE_LO, 10'd1023, 7'd127, 8'hFF);
        issue(ACT_SPARE_HI, 10'd0, 7'd0, 8'h00);
        for (int n = 0; n < int'(fsme_pkg::RST_ERASE_DELAY); n++)
            issue(fsme_pkg::ACT_TICK, 10'd0, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_TICK, 10'd512, 7'd64, 8'd0);        // idle tick does nothing

        // Fill the whole page buffer before any program; both extreme bytes at the ends.
        for (int k = 0; k < fsme_pkg::PAGE_BYTES; k++)
            issue(fsme_pkg::ACT_LOAD, 10'd0, 7'(k),
                  (k == 0) ? 8'h00 : (k == fsme_pkg::PAGE_BYTES - 1) ? fsme_pkg::ERASED_BYTE
                           : 8'($urandom_range(0, 255)));
        issue(fsme_pkg::ACT_PROGRAM, 10'd1023, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd1023, 7'd0, 8'd0);
        for (int n = 0; n < int'(fsme_pkg::RST_WRITE_DELAY); n++)
            issue(fsme_pkg::ACT_TICK, 10'd0, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd1023, 7'd127, 8'd0);

        // Plain copy mode ignores even the longest delays. Sector erase of the
        // last page aligns down to page 896 and leaves page 895 alone.
        configure(1'b0, 8'd255, 8'd255, 1'b0);
        issue(fsme_pkg::ACT_PROGRAM, 10'd895, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_ERASE_SEC, 10'd1023, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd895, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd896, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd1023, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_LOAD, 10'd0, 7'd0, 8'hA5);
        issue(fsme_pkg::ACT_PROGRAM, 10'd896, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd896, 7'd0, 8'd0);

        // Full emulation with zero delays finishes at once.
        configure(1'b1, 8'd0, 8'd0, 1'b0);
        issue(fsme_pkg::ACT_LOAD, 10'd0, 7'd0, 8'h3C);
        issue(fsme_pkg::ACT_PROGRAM, 10'd896, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd896, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_ERASE_SEC, 10'd0, 7'd0, 8'd0);
        issue(fsme_pkg::ACT_READ, 10'd127, 7'd127, 8'd0);

        // Random phases. The long result stall comes first; the second phase
        // runs with no idling; the slow-write phase usually ends still busy so
        // the following mode change lands mid-operation.
        run_phase(1'b0, 8'd255, 8'd255, 25, 75, 1'b0, 1'b1);
        run_phase(1'b1, 8'd1, 8'd2, 40, 75, 1'b1, 1'b0);
        run_phase(1'b1, 8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)),
                  25, 75, 1'b0, 1'b0);
        run_phase(1'b1, 8'd60, 8'd60, 40, 90, 1'b0, 1'b0);
        run_phase(1'b0, 8'd0, 8'd255, 20, 80, 1'b0, 1'b0);
        run_phase(1'b1, 8'($urandom_range(0, 9)), 8'($urandom_range(0, 9)),
                  25, 75, 1'b0, 1'b0);

        drain(8);
        $display("summary: %0d command words sent, %0d result words checked",
                 sb.words_in, sb.words_out);
        $display("summary: %0d completions, %0d busy bounces, %0d mismatches",
                 sb.n_done, sb.n_rejected, sb.errors);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
